// ===== src/srrl_pkg.sv =====
`timescale 1ns / 1ps
// srrl_pkg: shared widths, item kinds and register indexes of the skip run range lookup
// no dependencies

package srrl_pkg;

  // field widths of the ports
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned SLOT_W      = 11;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned CP_W        = 21;
  localparam int unsigned RUN_COUNT_W = 7;
  localparam int unsigned OFF_COUNT_W = 12;
  localparam int unsigned CFG_DATA_W  = 12;
  localparam int unsigned CFG_IDX_W   = 1;

  // header layout: prefix sum in the low bits, offset start above it
  localparam int unsigned SUM_BITS    = 21;
  localparam int unsigned START_SHIFT = 21;
  localparam int unsigned START_W     = 11;

  // distance and running sum, one bit above the prefix sum for the borrow
  localparam int unsigned DIST_W      = SUM_BITS + 1;

  // default store depths
  localparam int unsigned DEF_RUN_DEPTH    = 64;
  localparam int unsigned DEF_OFFSET_DEPTH = 2048;

  typedef enum logic [KIND_W-1:0] {
    KIND_HDR    = 2'd0,
    KIND_OFF    = 2'd1,
    KIND_LOOKUP = 2'd2
  } kind_e;

  localparam logic [CFG_IDX_W-1:0] CFG_RUN_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_COUNT = 1'b1;

endpackage

// ===== src/skip_run_range_lookup.sv =====
`timescale 1ns / 1ps
// skip_run_range_lookup: membership test of a code point against run headers and offset bytes
// depends on srrl_pkg
//
// usage
//   the input channel (in_valid_i / in_ready_o) takes one item per transfer: a header write,
//   an offset byte write or a lookup. writes finish in the cycle of their transfer and give no
//   result; a kind that is none of the three is dropped. a lookup gives one result transfer on
//   the output channel (out_valid_o / out_ready_i) carrying in_set_o and table_fault_o.
//   run_count and offset_count must be written over cfg_we_i / cfg_index_i / cfg_wdata_i only
//   while idle; the user is bound to this, the block itself does not enforce it.
// operation
//   one item at a time. a lookup does a binary search (at most log2(RUN_DEPTH)+1 probes, each a
//   header read and a compare), then reads the run start, run end and prior prefix sum, then
//   walks the offset bytes (at most the run length minus one, one offset store read per cycle),
//   and then loads the output register. both stores have a single registered read port.
// reset
//   control state and the count registers clear; store contents are not cleared and an entry
//   read before it is written gives an undefined answer
// stalls
//   a finished result sits in the output register; writes are still taken meanwhile, and a
//   following lookup runs to its end and then waits until the output register is taken

module skip_run_range_lookup #(
  parameter int unsigned RUN_DEPTH    = srrl_pkg::DEF_RUN_DEPTH,
  parameter int unsigned OFFSET_DEPTH = srrl_pkg::DEF_OFFSET_DEPTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration writes
  input  logic                               cfg_we_i,
  input  logic [srrl_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [srrl_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // input items
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [srrl_pkg::KIND_W-1:0]        kind_i,
  input  logic [srrl_pkg::SLOT_W-1:0]        slot_i,
  input  logic [srrl_pkg::WORD_W-1:0]        word_value_i,
  input  logic [srrl_pkg::CP_W-1:0]          code_point_i,
  // results
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               in_set_o,
  output logic                               table_fault_o
);

  localparam int unsigned RUN_AW = $clog2(RUN_DEPTH);
  localparam int unsigned OFF_AW = $clog2(OFFSET_DEPTH);
  // run indexes and search bounds must hold RUN_DEPTH itself
  localparam int unsigned CW     = RUN_AW + 1;
  localparam int unsigned POS_W  = srrl_pkg::START_W;
  localparam int unsigned END_W  = srrl_pkg::OFF_COUNT_W;
  localparam int unsigned DIST_W = srrl_pkg::DIST_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_HDR1,
    S_HDR2,
    S_HDR3,
    S_WALK,
    S_OUT
  } state_e;

  state_e state_q;

  // configuration registers
  logic [srrl_pkg::RUN_COUNT_W-1:0] run_count_q;
  logic [srrl_pkg::OFF_COUNT_W-1:0] offset_count_q;

  // lookup working registers
  logic [srrl_pkg::SUM_BITS-1:0] key_q;
  logic [CW-1:0]                 lo_q, hi_q, size_q, mid_q, idx_q;
  logic [POS_W-1:0]              start_q, pos_q;
  logic [END_W-1:0]              end_q;
  logic [DIST_W-1:0]             total_q, sum_q;
  logic [POS_W-1:0]              rem_q;
  logic                          res_in_set_q, res_fault_q;

  // output register
  logic out_valid_q, in_set_q, table_fault_q;

  // stores
  logic [srrl_pkg::WORD_W-1:0] hdr_mem [RUN_DEPTH];
  logic [7:0]                  off_mem [OFFSET_DEPTH];
  logic [srrl_pkg::WORD_W-1:0] hdr_rdata_q;
  logic [7:0]                  off_rdata_q;

  logic                        in_xfer;
  logic                        hdr_we, off_we;
  logic [RUN_AW-1:0]           hdr_raddr;
  logic [OFF_AW-1:0]           off_raddr;
  logic [CW-1:0]               n_eff;
  logic [END_W-1:0]            ocount_eff;
  logic [CW-1:0]               mid_c;
  logic [CW-1:0]               mid_inc;
  logic [CW-1:0]               idx_inc;
  logic [CW-1:0]               idx_dec;
  logic [srrl_pkg::SUM_BITS-1:0] probe_sum;
  logic [POS_W-1:0]            hdr_start;
  logic [END_W-1:0]            hdr_end_clamped;
  logic [srrl_pkg::SUM_BITS-1:0] prev_sum;
  logic [END_W-1:0]            run_len;
  logic [DIST_W-1:0]           sum_next;
  logic [POS_W-1:0]            pos_inc;

  assign in_ready_o    = (state_q == S_IDLE);
  assign in_xfer       = in_valid_i && in_ready_o;
  assign out_valid_o   = out_valid_q;
  assign in_set_o      = in_set_q;
  assign table_fault_o = table_fault_q;

  // counts above the store depth act as the depth
  assign n_eff      = (32'(run_count_q) > RUN_DEPTH) ? CW'(RUN_DEPTH) : CW'(run_count_q);
  assign ocount_eff = (32'(offset_count_q) > OFFSET_DEPTH) ? END_W'(OFFSET_DEPTH)
                                                           : offset_count_q;

  assign mid_c     = lo_q + (size_q >> 1);
  assign mid_inc   = mid_q + CW'(1);
  assign idx_inc   = idx_q + CW'(1);
  assign idx_dec   = idx_q - CW'(1);
  assign probe_sum = hdr_rdata_q[srrl_pkg::SUM_BITS-1:0];
  assign hdr_start = hdr_rdata_q[srrl_pkg::START_SHIFT +: srrl_pkg::START_W];
  assign hdr_end_clamped = (32'(hdr_start) > OFFSET_DEPTH) ? END_W'(OFFSET_DEPTH)
                                                           : END_W'(hdr_start);
  assign prev_sum  = (idx_q == '0) ? '0 : probe_sum;
  assign run_len   = end_q - END_W'(start_q);
  assign sum_next  = sum_q + DIST_W'(off_rdata_q);
  assign pos_inc   = pos_q + POS_W'(1);

  assign hdr_we = in_xfer && (kind_i == srrl_pkg::KIND_HDR) && (32'(slot_i) < RUN_DEPTH);
  assign off_we = in_xfer && (kind_i == srrl_pkg::KIND_OFF) && (32'(slot_i) < OFFSET_DEPTH);

  // read addresses: each state issues the read whose data the next state uses
  always_comb begin
    hdr_raddr = mid_c[RUN_AW-1:0];
    off_raddr = pos_inc[OFF_AW-1:0];
    case (state_q)
      S_PROBE: hdr_raddr = (lo_q < hi_q) ? mid_c[RUN_AW-1:0] : lo_q[RUN_AW-1:0];
      S_CMP:   hdr_raddr = mid_inc[RUN_AW-1:0];
      S_HDR1:  hdr_raddr = idx_inc[RUN_AW-1:0];
      S_HDR2:  hdr_raddr = idx_dec[RUN_AW-1:0];
      default: hdr_raddr = mid_c[RUN_AW-1:0];
    endcase
    case (state_q)
      S_HDR3:  off_raddr = start_q[OFF_AW-1:0];
      S_WALK:  off_raddr = pos_inc[OFF_AW-1:0];
      default: off_raddr = pos_inc[OFF_AW-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      hdr_mem[slot_i[RUN_AW-1:0]] <= word_value_i;
    end
    hdr_rdata_q <= hdr_mem[hdr_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (off_we) begin
      off_mem[slot_i[OFF_AW-1:0]] <= word_value_i[7:0];
    end
    off_rdata_q <= off_mem[off_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      run_count_q    <= '0;
      offset_count_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we_i) begin
        case (cfg_index_i)
          srrl_pkg::CFG_RUN_COUNT:    run_count_q    <= cfg_wdata_i[srrl_pkg::RUN_COUNT_W-1:0];
          srrl_pkg::CFG_OFFSET_COUNT: offset_count_q <= cfg_wdata_i;
          default: ;
        endcase
      end

      // result taken by the receiver; in S_OUT the output register update covers this
      if (out_valid_q && out_ready_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          // header and offset writes go straight to the stores
          if (in_xfer && (kind_i == srrl_pkg::KIND_LOOKUP)) begin
            key_q   <= code_point_i;
            lo_q    <= '0;
            hi_q    <= n_eff;
            size_q  <= n_eff;
            state_q <= S_PROBE;
          end
        end

        S_PROBE: begin
          if (lo_q < hi_q) begin
            mid_q   <= mid_c;
            state_q <= S_CMP;
          end else if (lo_q >= n_eff) begin
            // run index out of range
            res_in_set_q <= 1'b0;
            res_fault_q  <= 1'b1;
            state_q      <= S_OUT;
          end else begin
            // header at lo is being read
            idx_q   <= lo_q;
            state_q <= S_HDR1;
          end
        end

        S_CMP: begin
          if (probe_sum < key_q) begin
            lo_q    <= mid_inc;
            size_q  <= hi_q - mid_inc;
            state_q <= S_PROBE;
          end else if (probe_sum > key_q) begin
            hi_q    <= mid_q;
            size_q  <= mid_q - lo_q;
            state_q <= S_PROBE;
          end else if (mid_inc >= n_eff) begin
            // exact hit on the last run
            res_in_set_q <= 1'b0;
            res_fault_q  <= 1'b1;
            state_q      <= S_OUT;
          end else begin
            // exact hit selects the next run, its header is being read
            idx_q   <= mid_inc;
            state_q <= S_HDR1;
          end
        end

        S_HDR1: begin
          start_q <= hdr_start;
          state_q <= S_HDR2;
        end

        S_HDR2: begin
          // run ends at the next header's start, or at the offset count for the last run
          end_q   <= (idx_inc < n_eff) ? hdr_end_clamped : ocount_eff;
          state_q <= S_HDR3;
        end

        S_HDR3: begin
          // borrow bit keeps a negative distance above any reachable sum
          total_q <= {1'b0, key_q} - {1'b0, prev_sum};
          sum_q   <= '0;
          pos_q   <= start_q;
          if (end_q <= END_W'(start_q)) begin
            // empty or inverted run
            res_in_set_q <= 1'b0;
            res_fault_q  <= 1'b1;
            state_q      <= S_OUT;
          end else if (run_len == END_W'(1)) begin
            res_in_set_q <= start_q[0];
            res_fault_q  <= 1'b0;
            state_q      <= S_OUT;
          end else begin
            rem_q   <= POS_W'(run_len - END_W'(1));
            state_q <= S_WALK;
          end
        end

        S_WALK: begin
          // offset byte at pos is in the read register, the next one is being read
          if (sum_next > total_q) begin
            res_in_set_q <= pos_q[0];
            res_fault_q  <= 1'b0;
            state_q      <= S_OUT;
          end else if (rem_q == POS_W'(1)) begin
            res_in_set_q <= pos_inc[0];
            res_fault_q  <= 1'b0;
            state_q      <= S_OUT;
          end else begin
            sum_q <= sum_next;
            pos_q <= pos_inc;
            rem_q <= rem_q - POS_W'(1);
          end
        end

        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q   <= 1'b1;
            in_set_q      <= res_in_set_q;
            table_fault_q <= res_fault_q;
            state_q       <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
